// ===== rtl/mf3x3_pkg.sv =====
// shared types and constants of the 3x3 rgb median filter
// depends on nothing; the top, front, queue and back files refer to it by scoped names
`default_nettype none

package mf3x3_pkg;

	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;
	localparam int PIX_W      = CHAN_W * NUM_CHAN;
	localparam int NUM_TAPS   = 9;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 16;
	localparam int IMG_W_W    = 11;
	localparam int MIN_DIM    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
	localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// channel positions inside an rgb word
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_median;
		logic [CHAN_W-1:0] green_median;
		logic [CHAN_W-1:0] blue_median;
		logic [COL_W-1:0]  centre_column;
		logic [ROW_W-1:0]  centre_row;
		logic              frame_done;
	} result_t;

	typedef struct packed {
		logic [IMG_W_W-1:0] image_width;
		logic [ROW_W-1:0]   image_height;
	} cfg_t;

	// one full 3x3 neighbourhood with its position
	typedef struct packed {
		rgb_t [NUM_TAPS-1:0] px;
		logic [COL_W-1:0]    centre_column;
		logic [ROW_W-1:0]    centre_row;
		logic                frame_done;
	} win_item_t;

	typedef struct packed {
		logic      valid;
		win_item_t item;
	} q_push_t;

endpackage

`default_nettype wire

// ===== rtl/median_filter_3x3_rgb.sv =====
// 3x3 median filter on a raster stream of rgb pixels.
//
// src channel: one pixel word (red_in, green_in, blue_in) per accepted transfer,
// taken when src_valid is high and src_stall is low, in raster order.
// dst channel: one result word per interior pixel (median of the 3x3 neighbourhood
// per colour, centre column and row, frame_done on the last interior pixel);
// border pixels give no word.
// cfg channel: index 0 image_width, index 1 image_height, written when cfg_valid
// and cfg_ready are high; cfg_ready is always high. write only while idle.
// throughput: one pixel per clock while src_stall is low, set by the line-store ram,
// which can take one read and one write every cycle. the result word of a pixel passes
// the front stage register, the queue, the two network stages and the output register.
// when dst_stall holds the output word, a 4-word queue keeps taking results;
// src_stall rises once the queue and the word in flight would fill it.
// reset: column and row return to zero, the window clears, width goes to 1024 and
// height to 480. the line stores get no clearing pass: the first two lines of a
// frame fill them before any of their entries reaches a result word.
`default_nettype none

module median_filter_3x3_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 src_valid,
	output      logic                                 src_stall,
	input  wire mf3x3_pkg::pixel_t                    src_data,
	output      logic                                 dst_valid,
	input  wire logic                                 dst_stall,
	output      mf3x3_pkg::result_t                   dst_data,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [mf3x3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mf3x3_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mf3x3_pkg::cfg_t               cfg_q;
	mf3x3_pkg::q_push_t            push;
	logic                          pop;
	logic                          q_valid;
	mf3x3_pkg::win_item_t          q_item;
	logic [mf3x3_pkg::QCNT_W-1:0]  q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= mf3x3_pkg::WIDTH_RESET;
			cfg_q.image_height <= mf3x3_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mf3x3_pkg::REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[mf3x3_pkg::IMG_W_W-1:0];
				end
				mf3x3_pkg::REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	mf3x3_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.q_count   (q_count),
		.push      (push)
	);

	mf3x3_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.count    (q_count)
	);

	mf3x3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (q_valid),
		.rd_item   (q_item),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

`default_nettype wire

// ===== rtl/mf3x3_ram.sv =====
// simple dual-port ram: one write port, one read port with registered read data
// depends on nothing
`default_nettype none

module mf3x3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mf3x3_front.sv =====
// front end: takes pixels, tracks column and row, keeps the line stores and window,
// and pushes every interior 3x3 neighbourhood toward the queue; uses mf3x3_pkg, mf3x3_ram
`default_nettype none

module mf3x3_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mf3x3_pkg::cfg_t                    cfg,
	input  wire logic                               src_valid,
	output      logic                               src_stall,
	input  wire mf3x3_pkg::pixel_t                  src_data,
	input  wire logic [mf3x3_pkg::QCNT_W-1:0]       q_count,
	output      mf3x3_pkg::q_push_t                 push
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = mf3x3_pkg::ROW_W;

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic              valid_s1;
	mf3x3_pkg::rgb_t   pix_s1;
	logic [CW-1:0]     col_s1;
	logic [RW-1:0]     row_s1;
	mf3x3_pkg::rgb_t   win_q [6];

	logic [WW-1:0]     width_eff;
	logic [RW-1:0]     height_eff;
	logic [WW-1:0]     col_next;
	logic [RW:0]       row_next;
	logic              accept;
	mf3x3_pkg::rgb_t   pix_in;
	logic [2*mf3x3_pkg::PIX_W-1:0] line_rd;
	mf3x3_pkg::rgb_t   top;
	mf3x3_pkg::rgb_t   mid;

	// effective frame size, saturated to the legal range
	always_comb begin
		if (cfg.image_width < mf3x3_pkg::IMG_W_W'(mf3x3_pkg::MIN_DIM)) begin
			width_eff = WW'(mf3x3_pkg::MIN_DIM);
		end else if (int'(cfg.image_width) > MAX_WIDTH) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(cfg.image_width);
		end
		if (cfg.image_height < RW'(mf3x3_pkg::MIN_DIM)) begin
			height_eff = RW'(mf3x3_pkg::MIN_DIM);
		end else begin
			height_eff = cfg.image_height;
		end
	end

	// hold off while queue plus the word in flight could fill it
	assign src_stall = (q_count + mf3x3_pkg::QCNT_W'(valid_s1))
		>= mf3x3_pkg::QCNT_W'(mf3x3_pkg::QDEPTH);
	assign accept    = src_valid & ~src_stall;
	assign pix_in    = {src_data.red_in, src_data.green_in, src_data.blue_in};
	assign col_next  = {1'b0, col_q} + WW'(1);
	assign row_next  = {1'b0, row_q} + (RW+1)'(1);

	// line stores: upper half is two lines above, lower half the line above
	mf3x3_ram #(
		.WIDTH (2 * mf3x3_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata ({mid, pix_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	assign top = line_rd[2*mf3x3_pkg::PIX_W-1:mf3x3_pkg::PIX_W];
	assign mid = line_rd[mf3x3_pkg::PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_next >= width_eff) begin
					col_q <= '0;
					if (row_next >= {1'b0, height_eff}) begin
						row_q <= '0;
					end else begin
						row_q <= row_next[RW-1:0];
					end
				end else begin
					col_q <= col_next[CW-1:0];
				end
			end
			if (valid_s1) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top;
				win_q[4] <= mid;
				win_q[5] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_in;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	always_comb begin
		push.valid              = valid_s1 && (col_s1 >= CW'(2)) && (row_s1 >= RW'(2));
		push.item.px[0]         = win_q[0];
		push.item.px[1]         = win_q[1];
		push.item.px[2]         = win_q[2];
		push.item.px[3]         = win_q[3];
		push.item.px[4]         = win_q[4];
		push.item.px[5]         = win_q[5];
		push.item.px[6]         = top;
		push.item.px[7]         = mid;
		push.item.px[8]         = pix_s1;
		push.item.centre_column = mf3x3_pkg::COL_W'(col_s1 - CW'(1));
		push.item.centre_row    = row_s1 - RW'(1);
		push.item.frame_done    = (({1'b0, col_s1} + WW'(1)) == width_eff)
			&& (({1'b0, row_s1} + (RW+1)'(1)) == {1'b0, height_eff});
	end

endmodule

`default_nettype wire

// ===== rtl/mf3x3_fifo.sv =====
// short queue of neighbourhood words between front and back
// uses mf3x3_pkg
`default_nettype none

module mf3x3_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mf3x3_pkg::q_push_t            push,
	input  wire logic                          pop,
	output      logic                          rd_valid,
	output      mf3x3_pkg::win_item_t          rd_item,
	output      logic [mf3x3_pkg::QCNT_W-1:0]  count
);

	mf3x3_pkg::win_item_t               mem_q [mf3x3_pkg::QDEPTH];
	logic [mf3x3_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [mf3x3_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [mf3x3_pkg::QCNT_W-1:0]       count_q;

	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + mf3x3_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mf3x3_pkg::QPTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + mf3x3_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - mf3x3_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (count_q < mf3x3_pkg::QCNT_W'(mf3x3_pkg::QDEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> (count_q == $past(count_q) + mf3x3_pkg::QCNT_W'(1)))
		else $error("queue count lost a word");

endmodule

`default_nettype wire

// ===== rtl/mf3x3_back.sv =====
// back end: three-stage median-of-nine network per channel, its last stage the output register
// uses mf3x3_pkg
`default_nettype none

module mf3x3_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_valid,
	input  wire mf3x3_pkg::win_item_t  rd_item,
	output      logic                  pop,
	output      logic                  dst_valid,
	input  wire logic                  dst_stall,
	output      mf3x3_pkg::result_t    dst_data
);

	typedef mf3x3_pkg::chan_t [2:0] trio_t;

	// sorted ascending: [0] low, [1] middle, [2] high
	function automatic trio_t sort3(mf3x3_pkg::chan_t a, mf3x3_pkg::chan_t b,
		mf3x3_pkg::chan_t c);
		mf3x3_pkg::chan_t x;
		mf3x3_pkg::chan_t y;
		mf3x3_pkg::chan_t z;
		mf3x3_pkg::chan_t t;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		return {z, y, x};
	endfunction

	function automatic mf3x3_pkg::chan_t max3(mf3x3_pkg::chan_t a, mf3x3_pkg::chan_t b,
		mf3x3_pkg::chan_t c);
		trio_t s;
		s = sort3(a, b, c);
		return s[2];
	endfunction

	function automatic mf3x3_pkg::chan_t min3(mf3x3_pkg::chan_t a, mf3x3_pkg::chan_t b,
		mf3x3_pkg::chan_t c);
		trio_t s;
		s = sort3(a, b, c);
		return s[0];
	endfunction

	function automatic mf3x3_pkg::chan_t med3(mf3x3_pkg::chan_t a, mf3x3_pkg::chan_t b,
		mf3x3_pkg::chan_t c);
		mf3x3_pkg::chan_t lo;
		mf3x3_pkg::chan_t hi;
		mf3x3_pkg::chan_t hm;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		hm = (hi < c) ? hi : c;
		return (lo > hm) ? lo : hm;
	endfunction

	logic                en;
	logic                valid_s1;
	logic                valid_s2;
	logic                dst_valid_q;
	mf3x3_pkg::result_t  res_q;

	trio_t               sort_s1 [mf3x3_pkg::NUM_CHAN][3];
	mf3x3_pkg::chan_t    lo_max_s2 [mf3x3_pkg::NUM_CHAN];
	mf3x3_pkg::chan_t    mid_med_s2 [mf3x3_pkg::NUM_CHAN];
	mf3x3_pkg::chan_t    hi_min_s2 [mf3x3_pkg::NUM_CHAN];
	logic [mf3x3_pkg::COL_W-1:0] col_s1, col_s2;
	logic [mf3x3_pkg::ROW_W-1:0] row_s1, row_s2;
	logic                done_s1, done_s2;

	assign en        = ~dst_valid_q | ~dst_stall;
	assign pop       = en & rd_valid;
	assign dst_valid = dst_valid_q;
	assign dst_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			dst_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= rd_valid;
			valid_s2    <= valid_s1;
			dst_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// sort each column of three
			for (int ch = 0; ch < mf3x3_pkg::NUM_CHAN; ch++) begin
				for (int k = 0; k < 3; k++) begin
					sort_s1[ch][k] <= sort3(rd_item.px[3*k][ch], rd_item.px[3*k+1][ch],
						rd_item.px[3*k+2][ch]);
				end
			end
			col_s1  <= rd_item.centre_column;
			row_s1  <= rd_item.centre_row;
			done_s1 <= rd_item.frame_done;

			// max of lows, median of middles, min of highs
			for (int ch = 0; ch < mf3x3_pkg::NUM_CHAN; ch++) begin
				lo_max_s2[ch]  <= max3(sort_s1[ch][0][0], sort_s1[ch][1][0],
					sort_s1[ch][2][0]);
				mid_med_s2[ch] <= med3(sort_s1[ch][0][1], sort_s1[ch][1][1],
					sort_s1[ch][2][1]);
				hi_min_s2[ch]  <= min3(sort_s1[ch][0][2], sort_s1[ch][1][2],
					sort_s1[ch][2][2]);
			end
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			done_s2 <= done_s1;

			res_q.red_median    <= med3(lo_max_s2[mf3x3_pkg::CH_RED],
				mid_med_s2[mf3x3_pkg::CH_RED], hi_min_s2[mf3x3_pkg::CH_RED]);
			res_q.green_median  <= med3(lo_max_s2[mf3x3_pkg::CH_GREEN],
				mid_med_s2[mf3x3_pkg::CH_GREEN], hi_min_s2[mf3x3_pkg::CH_GREEN]);
			res_q.blue_median   <= med3(lo_max_s2[mf3x3_pkg::CH_BLUE],
				mid_med_s2[mf3x3_pkg::CH_BLUE], hi_min_s2[mf3x3_pkg::CH_BLUE]);
			res_q.centre_column <= col_s2;
			res_q.centre_row    <= row_s2;
			res_q.frame_done    <= done_s2;
		end
	end

endmodule

`default_nettype wire
